FILE: hdl/sfs_pkg.sv
package sfs_pkg;

  // Widths fixed by the field definitions
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FAULT_W  = 8;

  // Default width of the saturating age counters
  localparam int unsigned AGE_BITS_DEF = 16;

  // Hold timer saturates at the top of its 16-bit range
  localparam logic [TIMER_W-1:0] HOLD_MAX = {TIMER_W{1'b1}};

  // Input opcodes
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_LINK      = 3'd1,
    OP_REQUEST   = 3'd2,
    OP_RELAY     = 3'd3,
    OP_AUTOPILOT = 3'd4,
    OP_LOCAL_NAV = 3'd5,
    OP_GLOBAL_NAV = 3'd6,
    OP_SUBMERGED = 3'd7
  } op_e;

  // Mode codes
  localparam logic [1:0] MODE_SAFE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_LOCAL  = 2'd2;
  localparam logic [1:0] MODE_GLOBAL = 2'd3;

  // LED patterns
  localparam logic [1:0] LED_STOP   = 2'd0;
  localparam logic [1:0] LED_MANUAL = 2'd1;
  localparam logic [1:0] LED_AUTO   = 2'd2;

  // Fault bit positions
  localparam int unsigned FLT_LINK_LOST  = 0;
  localparam int unsigned FLT_LINK_DEAD  = 1;
  localparam int unsigned FLT_AP_LOST    = 2;
  localparam int unsigned FLT_RELAY_DEAD = 3;
  localparam int unsigned FLT_RAIL_OPEN  = 4;
  localparam int unsigned FLT_NOT_CLOSED = 5;
  localparam int unsigned FLT_WELDED     = 6;
  localparam int unsigned FLT_COMPLETE   = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AP_TO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_TO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_TO     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_MASK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_DISARM = 3'd7;

  // Register reset values
  localparam logic [TIMER_W-1:0] RST_LINK_TO  = 16'd5;
  localparam logic [TIMER_W-1:0] RST_RELAY_TO = 16'd15;
  localparam logic [TIMER_W-1:0] RST_AP_TO    = 16'd30;
  localparam logic [TIMER_W-1:0] RST_REQ_TO   = 16'd5;
  localparam logic [TIMER_W-1:0] RST_HOLD     = 16'd50;
  localparam logic [TIMER_W-1:0] RST_SUB_TO   = 16'd5;
  localparam logic [MASK_W-1:0]  RST_SAFE_MASK = 8'd15;

  typedef struct packed {
    logic [2:0] opcode;
    logic       value_bit;
    logic       relay_commanded;
    logic       relay_mismatch;
    logic [1:0] mode_value;
  } in_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_bits;
    logic               all_ok;
    logic               health_permit;
    logic [1:0]         granted_mode;
    logic [1:0]         led_pattern;
    logic               link_loss_suppressed;
  } out_t;

  typedef struct packed {
    logic [TIMER_W-1:0] link_timeout;
    logic [TIMER_W-1:0] relay_timeout;
    logic [TIMER_W-1:0] autopilot_timeout;
    logic [TIMER_W-1:0] request_timeout;
    logic [TIMER_W-1:0] hold_ticks;
    logic [TIMER_W-1:0] submerged_timeout;
    logic [MASK_W-1:0]  safe_mask;
    logic               link_loss_disarm;
  } cfg_t;

endpackage

FILE: hdl/safety_fault_supervisor.sv
// Safety fault supervisor. Every input transfer is a status event or a tick;
// only a tick returns a result (fault bits, ok, permit, granted mode, LED,
// suppression flag). One transfer is taken per cycle while no tick is held: an
// accepted item sits in the input register while the evaluation logic
// computes from it, and when it moves on the supervisor state is updated and
// a tick's result is captured in the output register. The output register
// alone limits the rate: while a result waits to be taken, a following tick
// is held in the input register, status events still pass. Configuration
// writes take effect on the next cycle and should be made while no item is
// in flight. There is no clearing pass after reset.
module safety_fault_supervisor #(
  parameter int unsigned AGE_BITS = sfs_pkg::AGE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfs_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfs_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfs_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import sfs_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  logic in_vld_q;
  out_t out_q;
  logic out_vld_q;
  out_t res;
  logic res_vld;
  logic advance;

  sfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Item in the input register moves on unless it is a tick facing a full result
  assign advance    = in_vld_q && (!res_vld || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  sfs_core #(
    .AGE_BITS(AGE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (in_q),
    .cfg_i      (cfg),
    .res_valid_o(res_vld),
    .res_o      (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_ok_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.all_ok == (out_data_o.fault_bits == '0)))
    else $error("all_ok disagrees with fault bits");

  a_mode_permit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.granted_mode != MODE_SAFE) |-> out_data_o.health_permit)
    else $error("non-safe mode granted without permit");

  a_suppress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.link_loss_suppressed) |-> !out_data_o.fault_bits[FLT_LINK_LOST])
    else $error("link loss raised while suppressed");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && res_vld && out_vld_q && !out_ready_i) |=> (in_vld_q && $stable(in_q)))
    else $error("tick dropped while result stalled");

endmodule

FILE: hdl/sfs_cfg_regs.sv
module sfs_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfs_pkg::CFG_W-1:0]      cfg_wdata_i,
  output sfs_pkg::cfg_t                  cfg_o
);
  import sfs_pkg::*;

  cfg_t cfg_q;

  // Register file, values truncated to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_timeout      <= RST_LINK_TO;
      cfg_q.relay_timeout     <= RST_RELAY_TO;
      cfg_q.autopilot_timeout <= RST_AP_TO;
      cfg_q.request_timeout   <= RST_REQ_TO;
      cfg_q.hold_ticks        <= RST_HOLD;
      cfg_q.submerged_timeout <= RST_SUB_TO;
      cfg_q.safe_mask         <= RST_SAFE_MASK;
      cfg_q.link_loss_disarm  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LINK_TO:     cfg_q.link_timeout      <= cfg_wdata_i[TIMER_W-1:0];
        CFG_RELAY_TO:    cfg_q.relay_timeout     <= cfg_wdata_i[TIMER_W-1:0];
        CFG_AP_TO:       cfg_q.autopilot_timeout <= cfg_wdata_i[TIMER_W-1:0];
        CFG_REQ_TO:      cfg_q.request_timeout   <= cfg_wdata_i[TIMER_W-1:0];
        CFG_HOLD:        cfg_q.hold_ticks        <= cfg_wdata_i[TIMER_W-1:0];
        CFG_SUB_TO:      cfg_q.submerged_timeout <= cfg_wdata_i[TIMER_W-1:0];
        CFG_SAFE_MASK:   cfg_q.safe_mask         <= cfg_wdata_i[MASK_W-1:0];
        CFG_LINK_DISARM: cfg_q.link_loss_disarm  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/sfs_core.sv
module sfs_core #(
  parameter int unsigned AGE_BITS = sfs_pkg::AGE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  sfs_pkg::in_t   item_i,
  input  sfs_pkg::cfg_t  cfg_i,
  output logic           res_valid_o,
  output sfs_pkg::out_t  res_o
);
  import sfs_pkg::*;

  localparam int unsigned CMP_W = (AGE_BITS > TIMER_W) ? AGE_BITS : TIMER_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  function automatic logic [AGE_BITS-1:0] sat_inc(input logic [AGE_BITS-1:0] a);
    sat_inc = (a == AGE_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic fresh(input logic seen, input logic [AGE_BITS-1:0] age,
                                 input logic [TIMER_W-1:0] lim);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] l;
    a = CMP_W'(age);
    l = CMP_W'(lim);
    fresh = seen && (a <= l);
  endfunction

  // Source state
  logic [AGE_BITS-1:0] link_age_q, link_age_d;
  logic [AGE_BITS-1:0] req_age_q, req_age_d;
  logic [AGE_BITS-1:0] relay_age_q, relay_age_d;
  logic [AGE_BITS-1:0] ap_age_q, ap_age_d;
  logic [AGE_BITS-1:0] sub_age_q, sub_age_d;
  logic                link_seen_q, link_seen_d;
  logic                link_up_q, link_up_d;
  logic                req_seen_q, req_seen_d;
  logic [1:0]          req_mode_q, req_mode_d;
  logic                relay_seen_q, relay_seen_d;
  logic [2:0]          relay_stat_q, relay_stat_d;   // {mismatch, commanded, feedback}
  logic [1:0]          ap_stat_q, ap_stat_d;         // {seen, connected}
  logic [1:0]          nav_flags_q, nav_flags_d;     // {global, local}
  logic [1:0]          sub_stat_q, sub_stat_d;       // {seen, submerged}
  logic [1:0]          cur_mode_q, cur_mode_d;
  logic [TIMER_W-1:0]  hold_cnt_q, hold_cnt_d;
  logic                hold_run_q, hold_run_d;

  // Tick evaluation
  logic [AGE_BITS-1:0] t_link_age, t_req_age, t_relay_age, t_ap_age, t_sub_age;
  logic [TIMER_W-1:0]  hold_inc, t_hold_cnt;
  logic                t_hold_run;
  logic                suppress, link_ok, relay_fresh, nav_active, nav_flag;
  logic [FAULT_W-1:0]  faults, cls;
  logic [1:0]          requested, granted, led;

  always_comb begin
    t_link_age  = sat_inc(link_age_q);
    t_req_age   = sat_inc(req_age_q);
    t_relay_age = sat_inc(relay_age_q);
    t_ap_age    = sat_inc(ap_age_q);
    t_sub_age   = sat_inc(sub_age_q);
    hold_inc    = (hold_run_q && hold_cnt_q != HOLD_MAX) ? hold_cnt_q + 1'b1 : hold_cnt_q;

    suppress = sub_stat_q[0] && fresh(sub_stat_q[1], t_sub_age, cfg_i.submerged_timeout) &&
               (cur_mode_q == MODE_LOCAL);

    faults     = '0;
    link_ok    = fresh(link_seen_q, t_link_age, cfg_i.link_timeout);
    faults[FLT_LINK_DEAD] = !link_ok;
    faults[FLT_LINK_LOST] = (!link_ok || !link_up_q) && cfg_i.link_loss_disarm && !suppress;

    // Relay checks only trust a fresh status
    relay_fresh = fresh(relay_seen_q, t_relay_age, cfg_i.relay_timeout);
    if (!relay_fresh) begin
      faults[FLT_RELAY_DEAD] = 1'b1;
      faults[FLT_RAIL_OPEN]  = 1'b1;
    end else begin
      faults[FLT_RAIL_OPEN]  = !relay_stat_q[0];
      faults[FLT_NOT_CLOSED] = relay_stat_q[2] && relay_stat_q[1] && !relay_stat_q[0];
      faults[FLT_WELDED]     = relay_stat_q[2] && !relay_stat_q[1] && relay_stat_q[0];
    end

    faults[FLT_AP_LOST] = !ap_stat_q[0] ||
                          !fresh(ap_stat_q[1], t_ap_age, cfg_i.autopilot_timeout);

    // Mission complete hold timer
    nav_active = cur_mode_q[1];
    nav_flag   = (cur_mode_q == MODE_LOCAL) ? nav_flags_q[0] : nav_flags_q[1];
    t_hold_run = hold_run_q;
    t_hold_cnt = hold_inc;
    if (nav_active && nav_flag) begin
      t_hold_run = 1'b1;
      if (!hold_run_q) t_hold_cnt = '0;
      faults[FLT_COMPLETE] = (cfg_i.hold_ticks != '0) && (t_hold_cnt >= cfg_i.hold_ticks);
    end else if (!nav_active) begin
      t_hold_run = 1'b0;
      t_hold_cnt = '0;
    end

    // Mode grant
    cls       = faults & cfg_i.safe_mask;
    requested = fresh(req_seen_q, t_req_age, cfg_i.request_timeout) ? req_mode_q : MODE_SAFE;
    granted   = (cls != '0) ? MODE_SAFE : requested;

    priority if (faults[FLT_RAIL_OPEN]) led = LED_STOP;
    else if (granted == MODE_MANUAL)    led = LED_MANUAL;
    else if (granted[1])                led = LED_AUTO;
    else                                led = LED_STOP;
  end

  assign res_o.fault_bits           = faults;
  assign res_o.all_ok               = (faults == '0);
  assign res_o.health_permit        = (cls == '0);
  assign res_o.granted_mode         = granted;
  assign res_o.led_pattern          = led;
  assign res_o.link_loss_suppressed = suppress;
  assign res_valid_o = (op_e'(item_i.opcode) == OP_TICK);

  // Next state per opcode
  always_comb begin
    link_age_d   = link_age_q;
    req_age_d    = req_age_q;
    relay_age_d  = relay_age_q;
    ap_age_d     = ap_age_q;
    sub_age_d    = sub_age_q;
    link_seen_d  = link_seen_q;
    link_up_d    = link_up_q;
    req_seen_d   = req_seen_q;
    req_mode_d   = req_mode_q;
    relay_seen_d = relay_seen_q;
    relay_stat_d = relay_stat_q;
    ap_stat_d    = ap_stat_q;
    nav_flags_d  = nav_flags_q;
    sub_stat_d   = sub_stat_q;
    cur_mode_d   = cur_mode_q;
    hold_cnt_d   = hold_cnt_q;
    hold_run_d   = hold_run_q;
    unique case (op_e'(item_i.opcode))
      OP_TICK: begin
        link_age_d  = t_link_age;
        req_age_d   = t_req_age;
        relay_age_d = t_relay_age;
        ap_age_d    = t_ap_age;
        sub_age_d   = t_sub_age;
        hold_cnt_d  = t_hold_cnt;
        hold_run_d  = t_hold_run;
        cur_mode_d  = granted;
      end
      OP_LINK: begin
        link_seen_d = 1'b1;
        link_up_d   = item_i.value_bit;
        link_age_d  = '0;
      end
      OP_REQUEST: begin
        req_seen_d = 1'b1;
        req_mode_d = item_i.mode_value;
        req_age_d  = '0;
      end
      OP_RELAY: begin
        relay_seen_d = 1'b1;
        relay_stat_d = {item_i.relay_mismatch, item_i.relay_commanded, item_i.value_bit};
        relay_age_d  = '0;
      end
      OP_AUTOPILOT: begin
        ap_stat_d = {1'b1, item_i.value_bit};
        ap_age_d  = '0;
      end
      OP_LOCAL_NAV:  nav_flags_d = {nav_flags_q[1], item_i.value_bit};
      OP_GLOBAL_NAV: nav_flags_d = {item_i.value_bit, nav_flags_q[0]};
      OP_SUBMERGED: begin
        sub_stat_d = {1'b1, item_i.value_bit};
        sub_age_d  = '0;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_age_q   <= AGE_MAX;
      req_age_q    <= AGE_MAX;
      relay_age_q  <= AGE_MAX;
      ap_age_q     <= AGE_MAX;
      sub_age_q    <= AGE_MAX;
      link_seen_q  <= 1'b0;
      link_up_q    <= 1'b0;
      req_seen_q   <= 1'b0;
      req_mode_q   <= MODE_SAFE;
      relay_seen_q <= 1'b0;
      relay_stat_q <= '0;
      ap_stat_q    <= '0;
      nav_flags_q  <= '0;
      sub_stat_q   <= '0;
      cur_mode_q   <= MODE_SAFE;
      hold_cnt_q   <= '0;
      hold_run_q   <= 1'b0;
    end else if (step_i) begin
      link_age_q   <= link_age_d;
      req_age_q    <= req_age_d;
      relay_age_q  <= relay_age_d;
      ap_age_q     <= ap_age_d;
      sub_age_q    <= sub_age_d;
      link_seen_q  <= link_seen_d;
      link_up_q    <= link_up_d;
      req_seen_q   <= req_seen_d;
      req_mode_q   <= req_mode_d;
      relay_seen_q <= relay_seen_d;
      relay_stat_q <= relay_stat_d;
      ap_stat_q    <= ap_stat_d;
      nav_flags_q  <= nav_flags_d;
      sub_stat_q   <= sub_stat_d;
      cur_mode_q   <= cur_mode_d;
      hold_cnt_q   <= hold_cnt_d;
      hold_run_q   <= hold_run_d;
    end
  end

endmodule
